/* rtl/assert_macros.svh */
// Assertion macros used by the checker file of the frame deframer.
// Needs nothing else; each macro expands to one labelled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, switched off while reset is low.
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error(msg);

// Implication form: antecedent must be followed by consequent.
`define ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* rtl/lfd_pkg.sv */
// Types, codes and the CRC-16 byte step of the length-framed deframer.
// No dependencies; imported by every module of the block.
`default_nettype none

package lfd_pkg;

    localparam logic [15:0] CRC_POLY = 16'h8005;
    localparam logic [15:0] CRC_INIT = 16'h0000;

    localparam int CFG_ADDR_W = 4;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_HEADER_FIRST   = 4'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_HEADER_SECOND  = 4'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_TRAILER_FIRST  = 4'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_TRAILER_SECOND = 4'd3;

    localparam logic [7:0] HEADER_FIRST_RST   = 8'd222;
    localparam logic [7:0] HEADER_SECOND_RST  = 8'd173;
    localparam logic [7:0] TRAILER_FIRST_RST  = 8'd238;
    localparam logic [7:0] TRAILER_SECOND_RST = 8'd237;

    localparam logic RESULT_PAYLOAD = 1'b0;
    localparam logic RESULT_VERDICT = 1'b1;

    typedef enum logic [2:0] {
        V_OK      = 3'd0,
        V_SHORT   = 3'd1,
        V_HEADER  = 3'd2,
        V_TRAILER = 3'd3,
        V_CRC     = 3'd4
    } verdict_t;

    typedef enum logic [3:0] {
        PH_HDR1    = 4'd0,
        PH_HDR2    = 4'd1,
        PH_TYPE    = 4'd2,
        PH_LENH    = 4'd3,
        PH_LENL    = 4'd4,
        PH_PAYLOAD = 4'd5,
        PH_TRL1    = 4'd6,
        PH_TRL2    = 4'd7,
        PH_CRCH    = 4'd8,
        PH_CRCL    = 4'd9,
        PH_SKIP    = 4'd10
    } phase_t;

    typedef struct packed {
        logic [7:0] header_first;
        logic [7:0] header_second;
        logic [7:0] trailer_first;
        logic [7:0] trailer_second;
    } cfg_t;

    typedef struct packed {
        logic       valid;
        logic       kind;
        logic [7:0] frame_kind;
        logic [7:0] payload;
        verdict_t   verdict;
    } result_t;

    // MSB-first CRC-16, one byte per call
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

/* rtl/length_framed_deframer_crc16.sv */
// A result is registered and appears on the m_ side in the cycle after its item is accepted.
// Throughput: one byte per cycle while the m_ side does not stall; the parser state and
// the CRC-16 byte step update together, and the result register refills while it is being drained.
// Reset (aresetn low, synchronous): parser back to the first header byte, result
// register empty, header/trailer registers to 222, 173, 238, 237.
`default_nettype none

module length_framed_deframer_crc16
    import lfd_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [7:0]            cfg_wdata,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [7:0]            s_rx_byte,
    input  wire logic                  s_end_of_buffer,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic                       m_result_kind,
    output logic [7:0]                 m_frame_kind,
    output logic [7:0]                 m_payload_byte,
    output logic [2:0]                 m_verdict
);

    cfg_t    cfg_reg, cfg_next;
    result_t res;
    logic    accept;
    logic    m_valid_reg, m_valid_next;
    result_t out_reg;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_HEADER_FIRST:   cfg_next.header_first   = cfg_wdata;
                REG_HEADER_SECOND:  cfg_next.header_second  = cfg_wdata;
                REG_TRAILER_FIRST:  cfg_next.trailer_first  = cfg_wdata;
                REG_TRAILER_SECOND: cfg_next.trailer_second = cfg_wdata;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    lfd_parse u_parse (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (accept),
        .rx_byte (s_rx_byte),
        .eob     (s_end_of_buffer),
        .cfg     (cfg_reg),
        .res     (res)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept && res.valid) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.header_first   <= HEADER_FIRST_RST;
            cfg_reg.header_second  <= HEADER_SECOND_RST;
            cfg_reg.trailer_first  <= TRAILER_FIRST_RST;
            cfg_reg.trailer_second <= TRAILER_SECOND_RST;
            m_valid_reg            <= 1'b0;
        end else begin
            cfg_reg     <= cfg_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // result payload, loaded only when an item produces a result
    always_ff @(posedge aclk) begin
        if (accept && res.valid) begin
            out_reg <= res;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_result_kind  = out_reg.kind;
    assign m_frame_kind   = out_reg.frame_kind;
    assign m_payload_byte = out_reg.payload;
    assign m_verdict      = out_reg.verdict;

endmodule

`default_nettype wire

/* rtl/lfd_parse.sv */
// Frame parser: phase state machine, running CRC and length counter.
// Uses lfd_pkg; produces at most one result per accepted item, combinationally.
`default_nettype none

module lfd_parse
    import lfd_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       step_en,
    input  wire logic [7:0] rx_byte,
    input  wire logic       eob,
    input  wire cfg_t       cfg,
    output result_t         res
);

    phase_t      phase_reg, phase_next;
    logic [7:0]  kind_reg, kind_next;
    logic [7:0]  len_hi_reg, len_hi_next;
    logic [15:0] left_reg, left_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  crch_reg, crch_next;

    logic        fault;
    verdict_t    fault_code;
    logic        have_payload;
    logic        short_buf;

    // next phase
    always_comb begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_HDR1:    if (!fault) phase_next = PH_HDR2;
            PH_HDR2:    if (!fault) phase_next = PH_TYPE;
            PH_TYPE:    phase_next = PH_LENH;
            PH_LENH:    phase_next = PH_LENL;
            PH_LENL:    phase_next = ({len_hi_reg, rx_byte} != 16'd0) ? PH_PAYLOAD : PH_TRL1;
            PH_PAYLOAD: if (left_reg == 16'd1) phase_next = PH_TRL1;
            PH_TRL1:    if (!fault) phase_next = PH_TRL2;
            PH_TRL2:    if (!fault) phase_next = PH_CRCH;
            PH_CRCH:    phase_next = PH_CRCL;
            PH_CRCL:    phase_next = PH_SKIP;
            PH_SKIP:    phase_next = PH_SKIP;
            default:    phase_next = phase_reg;
        endcase
        if (fault) begin
            phase_next = PH_SKIP;
        end
        if (eob) begin
            phase_next = PH_HDR1;
        end
    end

    // datapath and result
    always_comb begin
        kind_next    = kind_reg;
        len_hi_next  = len_hi_reg;
        left_next    = left_reg;
        crc_next     = crc_reg;
        crch_next    = crch_reg;
        fault        = 1'b0;
        fault_code   = V_OK;
        have_payload = 1'b0;
        unique case (phase_reg)
            PH_HDR1: begin
                kind_next   = 8'd0;
                len_hi_next = 8'd0;
                left_next   = 16'd0;
                crch_next   = 8'd0;
                crc_next    = CRC_INIT;
                if (rx_byte != cfg.header_first) begin
                    fault      = 1'b1;
                    fault_code = V_HEADER;
                end else begin
                    crc_next = crc16_byte(CRC_INIT, rx_byte);
                end
            end
            PH_HDR2: begin
                if (rx_byte != cfg.header_second) begin
                    fault      = 1'b1;
                    fault_code = V_HEADER;
                end else begin
                    crc_next = crc16_byte(crc_reg, rx_byte);
                end
            end
            PH_TYPE: begin
                kind_next = rx_byte;
                crc_next  = crc16_byte(crc_reg, rx_byte);
            end
            PH_LENH: begin
                len_hi_next = rx_byte;
                crc_next    = crc16_byte(crc_reg, rx_byte);
            end
            PH_LENL: begin
                left_next = {len_hi_reg, rx_byte};
                crc_next  = crc16_byte(crc_reg, rx_byte);
            end
            PH_PAYLOAD: begin
                crc_next     = crc16_byte(crc_reg, rx_byte);
                left_next    = left_reg - 16'd1;
                have_payload = 1'b1;
            end
            PH_TRL1: begin
                if (rx_byte != cfg.trailer_first) begin
                    fault      = 1'b1;
                    fault_code = V_TRAILER;
                end else begin
                    crc_next = crc16_byte(crc_reg, rx_byte);
                end
            end
            PH_TRL2: begin
                if (rx_byte != cfg.trailer_second) begin
                    fault      = 1'b1;
                    fault_code = V_TRAILER;
                end else begin
                    crc_next = crc16_byte(crc_reg, rx_byte);
                end
            end
            PH_CRCH: begin
                crch_next = rx_byte;
            end
            PH_CRCL: begin
                fault      = 1'b1;
                fault_code = ({crch_reg, rx_byte} == crc_reg) ? V_OK : V_CRC;
            end
            PH_SKIP: begin
            end
            default: begin
            end
        endcase

        // buffer ran out mid-frame: short verdict replaces a payload item, but a fault verdict wins
        short_buf = eob && !fault && (phase_reg != PH_SKIP);

        res.frame_kind = kind_next;
        if (fault || short_buf) begin
            res.valid   = 1'b1;
            res.kind    = RESULT_VERDICT;
            res.payload = 8'd0;
            res.verdict = short_buf ? V_SHORT : fault_code;
        end else if (have_payload) begin
            res.valid   = 1'b1;
            res.kind    = RESULT_PAYLOAD;
            res.payload = rx_byte;
            res.verdict = V_OK;
        end else begin
            res.valid   = 1'b0;
            res.kind    = RESULT_PAYLOAD;
            res.payload = 8'd0;
            res.verdict = V_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HDR1;
            kind_reg   <= 8'd0;
            len_hi_reg <= 8'd0;
            left_reg   <= 16'd0;
            crc_reg    <= CRC_INIT;
            crch_reg   <= 8'd0;
        end else if (step_en) begin
            phase_reg  <= phase_next;
            kind_reg   <= kind_next;
            len_hi_reg <= len_hi_next;
            left_reg   <= left_next;
            crc_reg    <= crc_next;
            crch_reg   <= crch_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/lfd_checker.sv */
// Port-level checker for the deframer, bound to the top level below.
// Uses lfd_pkg for result and verdict codes and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module lfd_checker
    import lfd_pkg::*;
(
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_ready,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic       m_result_kind,
    input wire logic [7:0] m_frame_kind,
    input wire logic [7:0] m_payload_byte,
    input wire logic [2:0] m_verdict
);

    logic [19:0] out_bits;

    assign out_bits = {m_result_kind, m_frame_kind, m_payload_byte, m_verdict};

    // a stalled item keeps its contents
    `ASSERT_CLK(a_hold_stalled, aclk, aresetn,
        (m_valid && !m_ready) |=> (m_valid && $stable(out_bits)),
        "stalled result item changed")

    // the output side never blocks input while it is empty
    `ASSERT_IMPL(a_ready_empty, aclk, aresetn, !m_valid, s_ready,
        "input stalled with empty output register")

    `ASSERT_IMPL(a_payload_clean, aclk, aresetn,
        m_valid && (m_result_kind == RESULT_PAYLOAD), m_verdict == V_OK,
        "payload item carries a verdict code")

    `ASSERT_IMPL(a_verdict_legal, aclk, aresetn,
        m_valid && (m_result_kind == RESULT_VERDICT),
        (m_payload_byte == 8'd0) && (m_verdict <= V_CRC),
        "malformed verdict item")

endmodule

bind length_framed_deframer_crc16 lfd_checker u_lfd_checker (.*);

`default_nettype wire
